/* sv/ymodem_packet_receiver_macros.svh */
// Assertion helpers included by the receiver's top-level RTL file.
`ifndef YMODEM_PACKET_RECEIVER_MACROS_SVH
`define YMODEM_PACKET_RECEIVER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define YMR_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define YMR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/ymr_pkg.sv */
package ymr_pkg;

    localparam int unsigned PAYLOAD_BYTES_DEF = 128;
    localparam int unsigned BC_W              = 17;
    localparam int unsigned SIZE_W            = 25;

    localparam logic [15:0] CRC_POLY  = 16'h1021;
    localparam logic [7:0]  BYTE_SOH  = 8'h01;
    localparam logic [7:0]  BYTE_EOT  = 8'h04;
    localparam logic [7:0]  BYTE_ACK  = 8'h06;
    localparam logic [7:0]  BYTE_NAK  = 8'h15;
    localparam logic [7:0]  CHAR_C    = 8'h43;
    localparam logic [31:0] DONE_FLAG = 32'hAAAA_AAAA;

    localparam logic [1:0] ACT_TX    = 2'd0;
    localparam logic [1:0] ACT_ERASE = 2'd1;
    localparam logic [1:0] ACT_PROG  = 2'd2;
    localparam logic [1:0] ACT_RESET = 2'd3;

    localparam logic [1:0] PH_START = 2'd0;
    localparam logic [1:0] PH_DATA  = 2'd1;
    localparam logic [1:0] PH_EOT2  = 2'd2;
    localparam logic [1:0] PH_END   = 2'd3;

    localparam logic [1:0] REG_BASE   = 2'd0;
    localparam logic [1:0] REG_SIZE   = 2'd1;
    localparam logic [1:0] REG_SECTOR = 2'd2;

    // Fixed result sequences that do not read the payload memory.
    localparam logic [2:0] PLAN_POLL  = 3'd0;
    localparam logic [2:0] PLAN_START = 3'd1;
    localparam logic [2:0] PLAN_END   = 3'd2;
    localparam logic [2:0] PLAN_NAK   = 3'd3;
    localparam logic [2:0] PLAN_EOT2  = 3'd4;
    localparam logic [2:0] PLAN_ACK   = 3'd5;

    typedef struct packed {
        logic clear;
        logic load;
        logic shift;
    } crc_ctrl_t;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] tx_byte;
        logic       last;
    } plan_res_t;

    function automatic plan_res_t plan_entry(input logic [2:0] plan, input logic [1:0] step);
        plan_res_t r;
        r = '{ACT_TX, BYTE_ACK, 1'b1};
        unique case (plan)
            PLAN_POLL: r = '{ACT_TX, CHAR_C, 1'b1};
            PLAN_START:
            begin
                if (step == 2'd0)
                    r = '{ACT_ERASE, 8'h00, 1'b0};
                else if (step == 2'd1)
                    r = '{ACT_TX, BYTE_ACK, 1'b0};
                else
                    r = '{ACT_TX, CHAR_C, 1'b1};
            end
            PLAN_END:
            begin
                if (step == 2'd0)
                    r = '{ACT_PROG, 8'h00, 1'b0};
                else if (step == 2'd1)
                    r = '{ACT_TX, BYTE_ACK, 1'b0};
                else
                    r = '{ACT_RESET, 8'h00, 1'b1};
            end
            PLAN_NAK: r = '{ACT_TX, BYTE_NAK, 1'b1};
            PLAN_EOT2:
            begin
                if (step == 2'd0)
                    r = '{ACT_TX, BYTE_ACK, 1'b0};
                else
                    r = '{ACT_TX, CHAR_C, 1'b1};
            end
            default: r = '{ACT_TX, BYTE_ACK, 1'b1};
        endcase
        return r;
    endfunction

endpackage

/* sv/ymodem_packet_receiver.sv */
// YMODEM receiver for 128-byte SOH blocks with CRC-16: takes UART bytes (frame_end marks
// the last byte of a frame) and poll ticks, and issues transmit, sector erase, flash
// program and reset requests. A poll answered with 'C' passes the emit state; a payload
// byte passes the CRC state, where the bit-serial CRC unit runs one polynomial step per
// cycle. A frame end passes a decision state, after which fixed results are issued one per
// cycle while the output is not stalled; each of the 32 flash words of a data block passes
// a read and an output state, as the payload memory has a single read port. The input is
// stalled until the last result of an item is in the output register. The user must write
// configuration over the APB port only while the block is idle; the block does not enforce it.
module ymodem_packet_receiver #(
    parameter int unsigned PAYLOAD_BYTES = ymr_pkg::PAYLOAD_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic        command,
    input  logic [7:0]  rx_byte,
    input  logic        frame_end,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  action,
    output logic [7:0]  tx_byte,
    output logic [31:0] flash_address,
    output logic [31:0] flash_word,
    output logic        last,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

`include "ymodem_packet_receiver_macros.svh"

    localparam int unsigned WORDS     = PAYLOAD_BYTES / 4;
    localparam int unsigned WIDX_W    = $clog2(WORDS);
    localparam int unsigned PIDX_W    = $clog2(PAYLOAD_BYTES);
    localparam int unsigned BLK_SHIFT = $clog2(PAYLOAD_BYTES);
    localparam int unsigned BC_W      = ymr_pkg::BC_W;
    localparam int unsigned SIZE_W    = ymr_pkg::SIZE_W;
    localparam int unsigned END_W     = BC_W + BLK_SHIFT;
    localparam int unsigned CMP_W     = (END_W > SIZE_W) ? END_W : SIZE_W;

    localparam logic [7:0] POS_PAY_LO = 8'd3;
    localparam logic [7:0] POS_CRC_HI = 8'(PAYLOAD_BYTES + 3);
    localparam logic [7:0] POS_CRC_LO = 8'(PAYLOAD_BYTES + 4);
    localparam logic [7:0] LEN_FULL   = 8'(PAYLOAD_BYTES + 5);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_CRC     = 3'd1;
    localparam logic [2:0] S_DECIDE  = 3'd2;
    localparam logic [2:0] S_EMIT    = 3'd3;
    localparam logic [2:0] S_WRD_RD  = 3'd4;
    localparam logic [2:0] S_WRD_OUT = 3'd5;

    // Configuration registers.
    logic [31:0]       base_reg;
    logic [SIZE_W-1:0] size_reg;
    logic [7:0]        sector_reg;

    // Control state.
    logic [2:0]        state_reg, state_next;
    logic [1:0]        phase_reg, phase_next;
    logic [BC_W-1:0]   bc_reg, bc_next;
    logic [7:0]        pos_reg, pos_next;
    logic [23:0]       hdr_reg, hdr_next;
    logic [15:0]       rcrc_reg, rcrc_next;
    logic              len_ok_reg, len_ok_next;
    logic              fend_reg, fend_next;
    logic [2:0]        bit_cnt_reg, bit_cnt_next;
    logic [2:0]        plan_reg, plan_next;
    logic [1:0]        step_reg, step_next;
    logic [WIDX_W-1:0] widx_reg, widx_next;
    logic [31:0]       addr_reg, addr_next;
    logic              out_valid_reg, out_valid_next;

    // Result register and payload path.
    logic [1:0]        out_action_reg;
    logic [7:0]        out_tx_reg;
    logic [31:0]       out_addr_reg;
    logic [31:0]       out_word_reg;
    logic              out_last_reg;
    logic              out_load;
    logic [1:0]        ld_action;
    logic [7:0]        ld_tx;
    logic [31:0]       ld_addr;
    logic [31:0]       ld_word;
    logic              ld_last;

    logic [31:0]       acc_reg;
    logic [31:0]       rd_reg;
    logic [31:0]       mem [WORDS];

    logic              in_accept;
    logic              byte_acc;
    logic              is_pay;
    logic              out_free;
    logic [7:0]        pos_inc;
    logic [PIDX_W-1:0] pidx;
    logic [15:0]       crc_val;
    ymr_pkg::crc_ctrl_t crc_ctrl;
    ymr_pkg::plan_res_t res;

    logic [7:0]        hdr_first;
    logic [7:0]        hdr_seq;
    logic [7:0]        hdr_cmp;
    logic              soh_ok;
    logic              in_range;
    logic [END_W-1:0]  blk_end;
    logic [BC_W-1:0]   bc_prev;
    logic [31:0]       blk_off;

    assign in_accept = in_valid && (state_reg == S_IDLE);
    assign in_stall  = (state_reg != S_IDLE);
    assign byte_acc  = in_accept && !command;
    assign is_pay    = (pos_reg >= POS_PAY_LO) && (pos_reg < POS_CRC_HI);
    assign pos_inc   = (pos_reg != 8'hFF) ? (pos_reg + 8'd1) : pos_reg;
    assign pidx      = PIDX_W'(pos_reg - POS_PAY_LO);
    assign out_free  = !out_valid_reg || !out_stall;

    assign crc_ctrl.clear = byte_acc && (pos_reg == 8'd0);
    assign crc_ctrl.load  = byte_acc && is_pay;
    assign crc_ctrl.shift = (state_reg == S_CRC);

    ymr_crc u_crc (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (crc_ctrl),
        .data  (rx_byte),
        .crc   (crc_val)
    );

    assign hdr_first = hdr_reg[23:16];
    assign hdr_seq   = hdr_reg[15:8];
    assign hdr_cmp   = hdr_reg[7:0];
    assign soh_ok    = len_ok_reg && (crc_val == rcrc_reg) && (hdr_cmp == ~hdr_seq);
    assign blk_end   = {bc_reg, {BLK_SHIFT{1'b0}}};
    assign in_range  = (bc_reg != '0) && (CMP_W'(blk_end) <= CMP_W'(size_reg));
    assign bc_prev   = bc_reg - BC_W'(1);
    assign blk_off   = 32'({bc_prev, {BLK_SHIFT{1'b0}}});

    assign res = ymr_pkg::plan_entry(plan_reg, step_reg);

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        bc_next        = bc_reg;
        pos_next       = pos_reg;
        hdr_next       = hdr_reg;
        rcrc_next      = rcrc_reg;
        len_ok_next    = len_ok_reg;
        fend_next      = fend_reg;
        bit_cnt_next   = bit_cnt_reg;
        plan_next      = plan_reg;
        step_next      = step_reg;
        widx_next      = widx_reg;
        addr_next      = addr_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_load       = 1'b0;
        ld_action      = ymr_pkg::ACT_TX;
        ld_tx          = 8'h00;
        ld_addr        = 32'h0000_0000;
        ld_word        = 32'h0000_0000;
        ld_last        = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    if (command)
                    begin
                        if (phase_reg == ymr_pkg::PH_START)
                        begin
                            plan_next  = ymr_pkg::PLAN_POLL;
                            step_next  = 2'd0;
                            state_next = S_EMIT;
                        end
                    end
                    else
                    begin
                        if (pos_reg == 8'd0)
                        begin
                            hdr_next  = {rx_byte, 16'h0000};
                            rcrc_next = 16'h0000;
                        end
                        else if (pos_reg == 8'd1)
                            hdr_next[15:8] = rx_byte;
                        else if (pos_reg == 8'd2)
                            hdr_next[7:0] = rx_byte;
                        else if (pos_reg == POS_CRC_HI)
                            rcrc_next = {rx_byte, 8'h00};
                        else if (pos_reg == POS_CRC_LO)
                            rcrc_next[7:0] = rx_byte;

                        pos_next    = frame_end ? 8'd0 : pos_inc;
                        len_ok_next = (pos_inc >= LEN_FULL);
                        fend_next   = frame_end;
                        if (is_pay)
                        begin
                            bit_cnt_next = 3'd0;
                            state_next   = S_CRC;
                        end
                        else if (frame_end)
                            state_next = S_DECIDE;
                    end
                end
            end

            S_CRC:
            begin
                bit_cnt_next = bit_cnt_reg + 3'd1;
                if (bit_cnt_reg == 3'd7)
                    state_next = fend_reg ? S_DECIDE : S_IDLE;
            end

            S_DECIDE:
            begin
                state_next = S_IDLE;
                step_next  = 2'd0;
                if (hdr_first == ymr_pkg::BYTE_SOH)
                begin
                    if (soh_ok)
                    begin
                        if ((phase_reg == ymr_pkg::PH_START) && (hdr_seq == 8'h00))
                        begin
                            phase_next = ymr_pkg::PH_DATA;
                            bc_next    = BC_W'(1);
                            plan_next  = ymr_pkg::PLAN_START;
                            state_next = S_EMIT;
                        end
                        else if ((phase_reg == ymr_pkg::PH_END) && (hdr_seq == 8'h00))
                        begin
                            phase_next = ymr_pkg::PH_START;
                            addr_next  = base_reg + 32'(size_reg) - 32'd4;
                            plan_next  = ymr_pkg::PLAN_END;
                            state_next = S_EMIT;
                        end
                        else if ((phase_reg == ymr_pkg::PH_DATA) && (hdr_seq == bc_reg[7:0]))
                        begin
                            bc_next = bc_reg + BC_W'(1);
                            if (in_range)
                            begin
                                addr_next  = base_reg + blk_off;
                                widx_next  = '0;
                                state_next = S_WRD_RD;
                            end
                            else
                            begin
                                plan_next  = ymr_pkg::PLAN_ACK;
                                state_next = S_EMIT;
                            end
                        end
                    end
                end
                else if (hdr_first == ymr_pkg::BYTE_EOT)
                begin
                    if (phase_reg == ymr_pkg::PH_DATA)
                    begin
                        phase_next = ymr_pkg::PH_EOT2;
                        plan_next  = ymr_pkg::PLAN_NAK;
                        state_next = S_EMIT;
                    end
                    else if (phase_reg == ymr_pkg::PH_EOT2)
                    begin
                        phase_next = ymr_pkg::PH_END;
                        plan_next  = ymr_pkg::PLAN_EOT2;
                        state_next = S_EMIT;
                    end
                end
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    ld_action      = res.action;
                    ld_tx          = res.tx_byte;
                    ld_last        = res.last;
                    if (res.action == ymr_pkg::ACT_ERASE)
                    begin
                        ld_addr = base_reg;
                        ld_word = 32'(sector_reg);
                    end
                    else if (res.action == ymr_pkg::ACT_PROG)
                    begin
                        ld_addr = addr_reg;
                        ld_word = ymr_pkg::DONE_FLAG;
                    end
                    step_next = step_reg + 2'd1;
                    if (res.last)
                        state_next = S_IDLE;
                end
            end

            S_WRD_RD:
                state_next = S_WRD_OUT;

            S_WRD_OUT:
            begin
                if (out_free)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    ld_action      = ymr_pkg::ACT_PROG;
                    ld_addr        = addr_reg;
                    ld_word        = rd_reg;
                    addr_next      = addr_reg + 32'd4;
                    widx_next      = widx_reg + WIDX_W'(1);
                    if (widx_reg == WIDX_W'(WORDS - 1))
                    begin
                        plan_next  = ymr_pkg::PLAN_ACK;
                        step_next  = 2'd0;
                        state_next = S_EMIT;
                    end
                    else
                        state_next = S_WRD_RD;
                end
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= ymr_pkg::PH_START;
            bc_reg        <= '0;
            pos_reg       <= 8'd0;
            hdr_reg       <= 24'h00_0000;
            rcrc_reg      <= 16'h0000;
            len_ok_reg    <= 1'b0;
            fend_reg      <= 1'b0;
            bit_cnt_reg   <= 3'd0;
            plan_reg      <= ymr_pkg::PLAN_POLL;
            step_reg      <= 2'd0;
            widx_reg      <= '0;
            addr_reg      <= 32'h0000_0000;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            bc_reg        <= bc_next;
            pos_reg       <= pos_next;
            hdr_reg       <= hdr_next;
            rcrc_reg      <= rcrc_next;
            len_ok_reg    <= len_ok_next;
            fend_reg      <= fend_next;
            bit_cnt_reg   <= bit_cnt_next;
            plan_reg      <= plan_next;
            step_reg      <= step_next;
            widx_reg      <= widx_next;
            addr_reg      <= addr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_action_reg <= ld_action;
            out_tx_reg     <= ld_tx;
            out_addr_reg   <= ld_addr;
            out_word_reg   <= ld_word;
            out_last_reg   <= ld_last;
        end
    end

    // Payload bytes are packed little-endian and written as one word per four bytes.
    always_ff @(posedge clk)
    begin
        if (byte_acc && is_pay)
        begin
            acc_reg <= {rx_byte, acc_reg[31:8]};
            if (pidx[1:0] == 2'b11)
                mem[pidx[PIDX_W-1:2]] <= {rx_byte, acc_reg[31:8]};
        end
        if (state_reg == S_WRD_RD)
            rd_reg <= mem[widx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg   <= 32'h0000_0000;
            size_reg   <= SIZE_W'(131072);
            sector_reg <= 8'h00;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[3:2])
                ymr_pkg::REG_BASE:   base_reg   <= pwdata;
                ymr_pkg::REG_SIZE:   size_reg   <= pwdata[SIZE_W-1:0];
                ymr_pkg::REG_SECTOR: sector_reg <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            ymr_pkg::REG_BASE:   prdata = base_reg;
            ymr_pkg::REG_SIZE:   prdata = 32'(size_reg);
            ymr_pkg::REG_SECTOR: prdata = 32'(sector_reg);
            default:             prdata = 32'h0000_0000;
        endcase
    end

    assign pready        = 1'b1;
    assign out_valid     = out_valid_reg;
    assign action        = out_action_reg;
    assign tx_byte       = out_tx_reg;
    assign flash_address = out_addr_reg;
    assign flash_word    = out_word_reg;
    assign last          = out_last_reg;

    `YMR_ASSERT_IMPL(a_phase_only_on_frame, phase_reg != $past(phase_reg), $past(state_reg) == S_DECIDE, "protocol phase changed outside a frame decision")
    `YMR_ASSERT_IMPL(a_count_only_on_frame, bc_reg != $past(bc_reg), $past(state_reg) == S_DECIDE, "block count changed outside a frame decision")
    `YMR_ASSERT_NEXT(a_word_is_program, (state_reg == S_WRD_OUT) && out_free, out_valid_reg && (out_action_reg == ymr_pkg::ACT_PROG) && !out_last_reg, "data word result is not a non-final program request")

endmodule

/* sv/ymr_crc.sv */
module ymr_crc (
    input  logic              clk,
    input  logic              rst_n,
    input  ymr_pkg::crc_ctrl_t ctrl,
    input  logic [7:0]        data,
    output logic [15:0]       crc
);

    logic [15:0] crc_reg;
    logic [15:0] crc_next;

    // One polynomial step per shift cycle; eight shifts complete a byte.
    always_comb
    begin
        crc_next = crc_reg;
        if (ctrl.clear)
            crc_next = 16'h0000;
        else if (ctrl.load)
            crc_next = crc_reg ^ {data, 8'h00};
        else if (ctrl.shift)
        begin
            if (crc_reg[15])
                crc_next = {crc_reg[14:0], 1'b0} ^ ymr_pkg::CRC_POLY;
            else
                crc_next = {crc_reg[14:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            crc_reg <= 16'h0000;
        else
            crc_reg <= crc_next;
    end

    assign crc = crc_reg;

endmodule

/* tb/ymodem_packet_receiver_tb.sv */
`timescale 1ns / 100ps

module ymodem_packet_receiver_tb;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 40;
    localparam int HOLD_CYCLES    = 250;
    localparam int FRAME_BYTES    = 133;

    // Ways a generated SOH packet can be framed.
    localparam int FORM_GOOD     = 0;
    localparam int FORM_BAD_CRC  = 1;
    localparam int FORM_BAD_PAIR = 2;
    localparam int FORM_SHORT    = 3;
    localparam int FORM_OVERLONG = 4;

    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  tx_byte;
        logic [31:0] flash_address;
        logic [31:0] flash_word;
        logic        last;
    } flash_request_t;

    class download_tracker;
        logic [31:0]    base_address;
        logic [24:0]    region_size;
        logic [7:0]     sector;
        logic [1:0]     phase;
        logic [16:0]    block_count;
        logic [7:0]     byte_pos;
        logic [23:0]    header;
        logic [15:0]    crc_acc;
        logic [15:0]    crc_rx;
        logic [7:0]     payload [ymr_pkg::PAYLOAD_BYTES_DEF];
        flash_request_t expected_requests [$];
        flash_request_t fresh [$];
        int             mismatches;
        int             requests_checked;

        function new();
            base_address = '0;
            region_size = 25'd131072;
            sector = '0;
            phase = ymr_pkg::PH_START;
            block_count = '0;
            byte_pos = '0;
            header = '0;
            crc_acc = '0;
            crc_rx = '0;
            mismatches = 0;
            requests_checked = 0;
        endfunction

        static function logic [15:0] crc16_step(logic [15:0] c, logic [7:0] b);
            logic [15:0] r;
            r = c ^ {b, 8'h00};
            for (int i = 0; i < 8; i++)
                r = r[15] ? ((r << 1) ^ ymr_pkg::CRC_POLY) : (r << 1);
            return r;
        endfunction

        function void set_register(logic [1:0] index, logic [31:0] value);
            case (index)
                ymr_pkg::REG_BASE:   base_address = value;
                ymr_pkg::REG_SIZE:   region_size = value[24:0];
                ymr_pkg::REG_SECTOR: sector = value[7:0];
                default:    ;
            endcase
        endfunction

        function int pending();
            return expected_requests.size();
        endfunction

        function void push(logic [1:0] act, logic [7:0] tx, logic [31:0] addr,
                           logic [31:0] word);
            flash_request_t r;
            r.action = act;
            r.tx_byte = tx;
            r.flash_address = addr;
            r.flash_word = word;
            r.last = 1'b0;
            fresh.push_back(r);
        endfunction

        // Verdict on a complete SOH frame of full length.
        function void judge_packet();
            logic [7:0]  seq;
            logic [31:0] offset;
            logic [31:0] word;
            seq = header[15:8];
            if (crc_acc != crc_rx || header[7:0] != ~seq)
                return;
            if (phase == ymr_pkg::PH_START && seq == 8'd0)
            begin
                phase = ymr_pkg::PH_DATA;
                block_count = 17'd1;
                push(ymr_pkg::ACT_ERASE, 8'h00, base_address, {24'd0, sector});
                push(ymr_pkg::ACT_TX, ymr_pkg::BYTE_ACK, '0, '0);
                push(ymr_pkg::ACT_TX, ymr_pkg::CHAR_C, '0, '0);
            end
            else if (phase == ymr_pkg::PH_END && seq == 8'd0)
            begin
                push(ymr_pkg::ACT_PROG, 8'h00,
                     base_address + {7'd0, region_size} - 32'd4, ymr_pkg::DONE_FLAG);
                phase = ymr_pkg::PH_START;
                push(ymr_pkg::ACT_TX, ymr_pkg::BYTE_ACK, '0, '0);
                push(ymr_pkg::ACT_RESET, 8'h00, '0, '0);
            end
            else if (phase == ymr_pkg::PH_DATA && seq == block_count[7:0])
            begin
                // Blocks that run past the region are acknowledged but not programmed.
                if (block_count != 0 && ({15'd0, block_count} << 7) <= {7'd0, region_size})
                begin
                    offset = ({15'd0, block_count} - 32'd1) << 7;
                    for (int w = 0; w < 32; w++)
                    begin
                        word = {payload[4*w+3], payload[4*w+2], payload[4*w+1], payload[4*w]};
                        push(ymr_pkg::ACT_PROG, 8'h00, base_address + offset + 32'(4 * w),
                             word);
                    end
                end
                block_count = block_count + 17'd1;
                push(ymr_pkg::ACT_TX, ymr_pkg::BYTE_ACK, '0, '0);
            end
        endfunction

        function void note_item(logic c, logic [7:0] b, logic fe);
            logic [7:0]     pos;
            flash_request_t tail;
            fresh.delete();
            if (c)
            begin
                if (phase == ymr_pkg::PH_START)
                    push(ymr_pkg::ACT_TX, ymr_pkg::CHAR_C, '0, '0);
            end
            else
            begin
                pos = byte_pos;
                if (pos == 0)
                begin
                    header = '0;
                    crc_acc = '0;
                    crc_rx = '0;
                end
                if (pos < 3)
                    header = header | ({16'd0, b} << (8 * (2 - pos)));
                else if (pos < 3 + ymr_pkg::PAYLOAD_BYTES_DEF)
                begin
                    payload[pos - 3] = b;
                    crc_acc = crc16_step(crc_acc, b);
                end
                else if (pos == 3 + ymr_pkg::PAYLOAD_BYTES_DEF)
                    crc_rx = {b, 8'h00};
                else if (pos == 4 + ymr_pkg::PAYLOAD_BYTES_DEF)
                    crc_rx[7:0] = b;
                if (pos < 255)
                    pos = pos + 8'd1;
                if (fe)
                begin
                    byte_pos = '0;
                    if (header[23:16] == ymr_pkg::BYTE_SOH)
                    begin
                        if (pos >= FRAME_BYTES)
                            judge_packet();
                    end
                    else if (header[23:16] == ymr_pkg::BYTE_EOT)
                    begin
                        if (phase == ymr_pkg::PH_DATA)
                        begin
                            phase = ymr_pkg::PH_EOT2;
                            push(ymr_pkg::ACT_TX, ymr_pkg::BYTE_NAK, '0, '0);
                        end
                        else if (phase == ymr_pkg::PH_EOT2)
                        begin
                            phase = ymr_pkg::PH_END;
                            push(ymr_pkg::ACT_TX, ymr_pkg::BYTE_ACK, '0, '0);
                            push(ymr_pkg::ACT_TX, ymr_pkg::CHAR_C, '0, '0);
                        end
                    end
                end
                else
                    byte_pos = pos;
            end
            if (fresh.size() > 0)
            begin
                tail = fresh.pop_back();
                tail.last = 1'b1;
                fresh.push_back(tail);
            end
            foreach (fresh[i])
                expected_requests.push_back(fresh[i]);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $display("%0t: %s expected %h, got %h", $time, name, want, got);
                mismatches++;
            end
        endfunction

        function void check_request(flash_request_t got);
            flash_request_t want;
            requests_checked++;
            if (expected_requests.size() == 0)
            begin
                $display("%0t: unexpected result action %0d tx %h addr %h word %h last %b",
                         $time, got.action, got.tx_byte, got.flash_address, got.flash_word,
                         got.last);
                mismatches++;
                return;
            end
            want = expected_requests.pop_front();
            compare_field("action", 32'(want.action), 32'(got.action));
            compare_field("tx_byte", 32'(want.tx_byte), 32'(got.tx_byte));
            compare_field("flash_address", want.flash_address, got.flash_address);
            compare_field("flash_word", want.flash_word, got.flash_word);
            compare_field("last", 32'(want.last), 32'(got.last));
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        command = 1'b0;
    logic [7:0]  rx_byte = 8'h00;
    logic        frame_end = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  action;
    logic [7:0]  tx_byte;
    logic [31:0] flash_address;
    logic [31:0] flash_word;
    logic        last;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = 4'h0;
    logic [31:0] pwdata = 32'h0;
    logic [31:0] prdata;
    logic        pready;

    download_tracker tracker;
    logic [7:0]      frame_bytes [$];
    bit              calm = 1'b0;
    bit              hold_asked = 1'b0;
    int              items_sent = 0;
    int              sessions_done = 0;

    ymodem_packet_receiver dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .command       (command),
        .rx_byte       (rx_byte),
        .frame_end     (frame_end),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .action        (action),
        .tx_byte       (tx_byte),
        .flash_address (flash_address),
        .flash_word    (flash_word),
        .last          (last),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Mostly short pauses, now and then a long one.
    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(3, 1);
        if (r < 98)
            return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    task automatic send_item(input logic c, input logic [7:0] b, input logic fe);
        int gap;
        command <= c;
        rx_byte <= b;
        frame_end <= fe;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        tracker.note_item(c, b, fe);
        items_sent++;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_bytes.size(); i++)
            send_item(1'b0, frame_bytes[i], i == frame_bytes.size() - 1);
    endtask

    task automatic make_block(input logic [7:0] seq, input int form);
        logic [15:0] crc;
        logic [7:0]  b;
        frame_bytes.delete();
        crc = '0;
        frame_bytes.push_back(ymr_pkg::BYTE_SOH);
        frame_bytes.push_back(seq);
        if (form == FORM_BAD_PAIR)
            frame_bytes.push_back(~seq ^ (8'd1 << $urandom_range(7)));
        else
            frame_bytes.push_back(~seq);
        for (int i = 0; i < ymr_pkg::PAYLOAD_BYTES_DEF; i++)
        begin
            b = 8'($urandom);
            frame_bytes.push_back(b);
            crc = download_tracker::crc16_step(crc, b);
        end
        if (form == FORM_BAD_CRC)
            crc = crc ^ (16'd1 << $urandom_range(15));
        frame_bytes.push_back(crc[15:8]);
        frame_bytes.push_back(crc[7:0]);
        if (form == FORM_SHORT)
            repeat ($urandom_range(20, 1)) void'(frame_bytes.pop_back());
        // Trailing bytes push the byte count into saturation; they are ignored.
        if (form == FORM_OVERLONG)
            repeat (130) frame_bytes.push_back(8'($urandom));
    endtask

    task automatic send_block(input logic [7:0] seq, input int form);
        make_block(seq, form);
        send_frame();
    endtask

    // A rejected copy now and then, followed by the good one.
    task automatic deliver_block(input logic [7:0] seq, input bit overlong);
        if ($urandom_range(3) == 0)
            send_block(seq, $urandom_range(FORM_SHORT, FORM_BAD_CRC));
        send_block(seq, overlong ? FORM_OVERLONG : FORM_GOOD);
    endtask

    task automatic send_noise();
        int         n;
        logic [7:0] b;
        n = $urandom_range(4, 1);
        for (int i = 0; i < n; i++)
        begin
            b = 8'($urandom);
            if (i == 0 && b == ymr_pkg::BYTE_EOT)
                b = 8'h02;
            send_item(1'b0, b, i == n - 1);
        end
    endtask

    task automatic send_eot();
        if ($urandom_range(1) == 0)
            send_item(1'b0, ymr_pkg::BYTE_EOT, 1'b1);
        else
        begin
            send_item(1'b0, ymr_pkg::BYTE_EOT, 1'b0);
            send_item(1'b0, 8'($urandom), 1'b1);
        end
    endtask

    task automatic run_session(input int data_blocks, input bit overlong);
        repeat ($urandom_range(3, 1)) send_item(1'b1, 8'($urandom), 1'($urandom));
        if ($urandom_range(1) == 1)
            send_noise();
        // A data block before block zero belongs to no phase and is dropped.
        if ($urandom_range(2) == 0)
            send_block(8'd1, FORM_GOOD);
        deliver_block(8'd0, 1'b0);
        for (int k = 1; k <= data_blocks; k++)
        begin
            calm = ($urandom_range(4) == 0);
            if ($urandom_range(3) == 0)
                send_item(1'b1, 8'($urandom), 1'($urandom));
            if ($urandom_range(4) == 0)
                send_block(8'd0, FORM_GOOD);
            deliver_block(8'(k), overlong && k == 1);
            // A repeated block no longer matches the counter.
            if ($urandom_range(4) == 0)
                send_block(8'(k), FORM_GOOD);
        end
        calm = 1'b0;
        send_eot();
        send_eot();
        if ($urandom_range(1) == 0)
            send_eot();
        deliver_block(8'd0, 1'b0);
        sessions_done++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (tracker.pending() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(input logic [1:0] index, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {index, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        tracker.set_register(index, value);
        @(posedge clk);
    endtask

    task automatic configure(input logic [31:0] base, input logic [31:0] size,
                             input logic [31:0] sector_no);
        apb_write(ymr_pkg::REG_BASE, base);
        apb_write(ymr_pkg::REG_SIZE, size);
        apb_write(ymr_pkg::REG_SECTOR, sector_no);
    endtask

    initial
    begin : result_side
        int             stall_left;
        int             hold_left;
        bit             hold_served;
        flash_request_t got;
        stall_left = 0;
        hold_left = 0;
        hold_served = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                got.action = action;
                got.tx_byte = tx_byte;
                got.flash_address = flash_address;
                got.flash_word = flash_word;
                got.last = last;
                tracker.check_request(got);
            end
            if (hold_asked && !hold_served)
            begin
                hold_served = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (calm)
                out_stall <= 1'b0;
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                stall_left = pick_gap();
                out_stall <= (stall_left > 0);
                if (stall_left > 0)
                    stall_left--;
            end
        end
    end

    initial
    begin : watchdog
        int idle;
        idle = 0;
        while (idle < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle = 0;
            else
                idle++;
        end
        $display("%0t: nothing moved for %0d cycles", $time, idle);
        $display("ymodem_packet_receiver test failed");
        $finish;
    end

    initial
    begin : stimulus
        tracker = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Polls while the receiver holds off: the block fills up and stalls its input.
        hold_asked = 1'b1;
        calm = 1'b1;
        send_item(1'b1, 8'hFF, 1'b1);
        send_item(1'b1, 8'h00, 1'b0);
        send_item(1'b1, 8'h5A, 1'b1);
        send_item(1'b1, 8'hA5, 1'b0);
        calm = 1'b0;
        // EOT in the start phase, a short SOH frame, an STX frame and stray bytes.
        send_item(1'b0, ymr_pkg::BYTE_EOT, 1'b1);
        send_item(1'b0, ymr_pkg::BYTE_SOH, 1'b0);
        send_item(1'b0, 8'h00, 1'b0);
        send_item(1'b0, 8'hFF, 1'b1);
        send_item(1'b0, 8'h02, 1'b0);
        send_item(1'b0, 8'h01, 1'b0);
        send_item(1'b0, 8'hFE, 1'b1);
        send_item(1'b0, 8'hFF, 1'b1);
        send_item(1'b0, 8'h00, 1'b1);
        wait_drained();

        configure(32'h0000_0000, 32'd256, 32'd0);
        run_session(3, 1'b0);
        wait_drained();

        configure(32'hFFFF_FFC0, 32'd16777216, 32'd255);
        run_session(2, 1'b1);
        wait_drained();

        configure(32'hFFFF_FFFF, 32'd384, 32'hA5);
        run_session(4, 1'b0);
        wait_drained();

        $display("Sent %0d items over %0d download sessions with three region settings.",
                 items_sent, sessions_done);
        $display("Checked %0d results, with rejected packets, overruns and address wrap.",
                 tracker.requests_checked);
        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("ymodem_packet_receiver test passed");
        else
            $display("ymodem_packet_receiver test failed");
        $finish;
    end

endmodule
